### src/omi_pkg.sv
// Shared types, constants and arithmetic helpers for the mecanum odometry integrator.
`default_nettype none
package omi_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int W_CIDX       = $clog2(ATAN_LEN);
    localparam int W_CFG_IDX    = 2;
    localparam int W_CFG_DATA   = 18;

    localparam logic [W_CFG_IDX-1:0] CFG_WHEEL_RADIUS  = 2'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_ANGULAR_RATIO = 2'd1;

    localparam logic [15:0] WHEEL_RADIUS_RST  = 16'd3277;
    localparam logic [17:0] ANGULAR_RATIO_RST = 18'd32768;

    // pi/30 in Q24
    localparam logic [20:0]        RIM_K       = 21'd1756906;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [30:0] PI_Q16      = 31'sd205887;
    localparam logic signed [30:0] TWO_PI_Q16  = 31'sd411775;
    localparam logic signed [48:0] DIV_HALF    = 49'sd500000;
    localparam logic signed [48:0] DIV_D_M1    = 49'sd999999;

    // 1000000 = 64 * 15625: shift out the 64, then reciprocal estimate and fix-up
    localparam logic [13:0] DIV_ODD    = 14'd15625;
    localparam logic [15:0] DIV_ODD_X2 = 16'd31250;
    localparam logic [15:0] DIV_ODD_X3 = 16'd46875;
    // floor(2^40 / 15625)
    localparam logic [26:0] DIV_RECIP  = 27'd70368744;

    typedef enum logic [1:0] {
        OP_UPDATE   = 2'd0,
        OP_SET_POSE = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef struct packed {
        t_op                kind;
        logic signed [15:0] rpm0;
        logic signed [15:0] rpm1;
        logic signed [15:0] rpm2;
        logic signed [15:0] rpm3;
        logic [19:0]        dt;
        logic signed [31:0] set_x;
        logic signed [31:0] set_y;
        logic signed [19:0] set_theta;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_R,
        ST_MUL_K,
        ST_VEL,
        ST_OMEGA,
        ST_CORDIC,
        ST_ROT,
        ST_SUM,
        ST_DT,
        ST_DIV_SET,
        ST_DIV_MUL,
        ST_DIV_REM,
        ST_DIV_FIX,
        ST_UPDATE
    } t_state;

    function automatic logic signed [27:0] atan_q24(input logic [W_CIDX-1:0] idx);
        logic signed [27:0] v;
        case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction

    // one wrap by 2*pi, then clamp
    function automatic logic signed [18:0] wrap_heading(input logic signed [30:0] a);
        logic signed [30:0] t;
        t = a;
        if (t > PI_Q16) begin
            t = t - TWO_PI_Q16;
        end else if (t < -PI_Q16) begin
            t = t + TWO_PI_Q16;
        end
        if (t > PI_Q16) begin
            t = PI_Q16;
        end
        if (t < -PI_Q16) begin
            t = -PI_Q16;
        end
        return t[18:0];
    endfunction

    function automatic logic signed [23:0] sat_24(input logic signed [56:0] v);
        logic signed [23:0] r;
        if (v > 57'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -57'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -33'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/omi_front.sv
// Input side: takes stream transactions, classifies the op and queues the items.
`default_nettype none
module omi_front
    import omi_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [167:0] i_s_axis_tdata,
    input  wire logic [1:0]   i_s_axis_tuser,
    output logic              o_q_valid,
    output t_item             o_q_item,
    input  wire logic         i_q_pop
);

    t_item      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    t_item      w_item;
    logic       w_push;

    always_comb begin
        w_item.kind      = t_op'(i_s_axis_tuser);
        w_item.rpm0      = i_s_axis_tdata[15:0];
        w_item.rpm1      = i_s_axis_tdata[31:16];
        w_item.rpm2      = i_s_axis_tdata[47:32];
        w_item.rpm3      = i_s_axis_tdata[63:48];
        w_item.dt        = i_s_axis_tdata[83:64];
        w_item.set_x     = i_s_axis_tdata[115:84];
        w_item.set_y     = i_s_axis_tdata[147:116];
        w_item.set_theta = i_s_axis_tdata[167:148];
    end

    assign o_s_axis_tready = (r_count != 2'd2);
    assign w_push          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_count != 2'd0);
    assign o_q_item        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

endmodule
`default_nettype wire

### src/omi_back.sv
// Execution side: kinematics, CORDIC rotation, time scaling and pose integration.
`default_nettype none
module omi_back
    import omi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [W_CFG_IDX-1:0]  i_cfg_index,
    input  wire logic [W_CFG_DATA-1:0] i_cfg_wdata,
    input  wire logic                  i_q_valid,
    input  wire t_item                 i_q_item,
    output logic                       o_q_pop,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [159:0]               o_m_axis_tdata
);

    t_state r_state, n_state;
    logic   w_start;
    logic   w_last_cordic;

    logic [15:0]        r_wheel_radius;
    logic [17:0]        r_angular_ratio;
    t_item              r_item;
    logic [W_CIDX-1:0]  r_cnt;
    logic               r_out_valid;

    logic signed [31:0] r_pos_x, r_pos_y;
    logic signed [18:0] r_heading;
    logic signed [23:0] r_vx, r_vy, r_omega;

    logic signed [34:0] r_p1 [3];
    logic signed [56:0] r_p2 [3];
    logic signed [33:0] r_lin_w;
    logic signed [33:0] r_cx, r_cy;
    logic signed [27:0] r_z;
    logic               r_fold;
    logic signed [57:0] r_m [4];
    logic signed [26:0] r_wx, r_wy;
    logic signed [47:0] r_n [3];
    logic [39:0]        r_a [3];
    logic [26:0]        r_qe [3];
    logic [15:0]        r_rem [3];
    logic               r_qneg [3];

    logic signed [17:0] w_s [3];
    logic signed [56:0] w_vel_rnd [3];
    logic signed [52:0] w_om_prod;
    logic signed [52:0] w_om_rnd;
    logic signed [27:0] w_z0;
    logic signed [33:0] w_xs, w_ys, w_c, w_s_rot;
    logic signed [58:0] w_sum_x, w_sum_y;
    logic signed [20:0] w_dts;
    logic signed [44:0] w_om_dt;
    logic signed [48:0] w_nh [3];
    logic signed [48:0] w_mag [3];
    logic [52:0]        w_qp [3];
    logic [40:0]        w_qd [3];
    logic [39:0]        w_r [3];
    logic [1:0]         w_corr [3];

    function automatic logic signed [17:0] i_rpm(input logic signed [15:0] v);
        return {{2{v[15]}}, v};
    endfunction

    // signed quotient of one lane
    function automatic logic signed [29:0] q_val(input int lane);
        logic signed [29:0] q;
        q = $signed({3'b0, r_qe[lane]});
        return r_qneg[lane] ? -q : q;
    endfunction

    // kinematic wheel combinations
    always_comb begin
        w_s[0] = 18'(i_rpm(r_item.rpm0)) + 18'(i_rpm(r_item.rpm1))
               + 18'(i_rpm(r_item.rpm2)) + 18'(i_rpm(r_item.rpm3));
        w_s[1] = -18'(i_rpm(r_item.rpm0)) + 18'(i_rpm(r_item.rpm1))
               + 18'(i_rpm(r_item.rpm2)) - 18'(i_rpm(r_item.rpm3));
        w_s[2] = -18'(i_rpm(r_item.rpm0)) + 18'(i_rpm(r_item.rpm1))
               - 18'(i_rpm(r_item.rpm2)) + 18'(i_rpm(r_item.rpm3));
    end

    always_comb begin
        w_vel_rnd[0] = (r_p2[0] + 57'sd268435456) >>> 29;
        w_vel_rnd[1] = (r_p2[1] + 57'sd268435456) >>> 29;
        w_vel_rnd[2] = (r_p2[2] + 57'sd1048576) >>> 21;
        w_om_prod    = r_lin_w * $signed({1'b0, r_angular_ratio});
        w_om_rnd     = (w_om_prod + 53'sd8388608) >>> 24;
        w_z0         = {{1{r_heading[18]}}, r_heading, 8'd0};
        w_xs         = r_cx >>> r_cnt;
        w_ys         = r_cy >>> r_cnt;
        w_c          = r_fold ? -r_cx : r_cx;
        w_s_rot      = r_fold ? -r_cy : r_cy;
        w_sum_x      = ({r_m[0][57], r_m[0]} - {r_m[1][57], r_m[1]} + 59'sd536870912) >>> 30;
        w_sum_y      = ({r_m[2][57], r_m[2]} + {r_m[3][57], r_m[3]} + 59'sd536870912) >>> 30;
        w_dts        = $signed({1'b0, r_item.dt});
        w_om_dt      = r_omega * w_dts;
    end

    // divide by 1000000: magnitude, estimate, remainder, fix-up of at most three
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_nh[k]  = $signed({r_n[k][47], r_n[k]}) + DIV_HALF;
            w_mag[k] = (w_nh[k] < 0) ? (DIV_D_M1 - w_nh[k]) : w_nh[k];
            w_qp[k]  = r_a[k][39:14] * DIV_RECIP;
            w_qd[k]  = r_qe[k] * DIV_ODD;
            w_r[k]   = r_a[k] - w_qd[k][39:0];
            priority if (r_rem[k] >= DIV_ODD_X3) begin
                w_corr[k] = 2'd3;
            end else if (r_rem[k] >= DIV_ODD_X2) begin
                w_corr[k] = 2'd2;
            end else if (r_rem[k] >= {2'b0, DIV_ODD}) begin
                w_corr[k] = 2'd1;
            end else begin
                w_corr[k] = 2'd0;
            end
        end
    end

    assign w_last_cordic = (r_cnt == W_CIDX'(CORDIC_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start && (i_q_item.kind == OP_UPDATE)) begin
                    n_state = ST_MUL_R;
                end
            end
            ST_MUL_R:   n_state = ST_MUL_K;
            ST_MUL_K:   n_state = ST_VEL;
            ST_VEL:     n_state = ST_OMEGA;
            ST_OMEGA:   n_state = ST_CORDIC;
            ST_CORDIC: begin
                if (w_last_cordic) begin
                    n_state = ST_ROT;
                end
            end
            ST_ROT:     n_state = ST_SUM;
            ST_SUM:     n_state = ST_DT;
            ST_DT:      n_state = ST_DIV_SET;
            ST_DIV_SET: n_state = ST_DIV_MUL;
            ST_DIV_MUL: n_state = ST_DIV_REM;
            ST_DIV_REM: n_state = ST_DIV_FIX;
            ST_DIV_FIX: n_state = ST_UPDATE;
            ST_UPDATE:  n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_start = (r_state == ST_IDLE) && i_q_valid && !r_out_valid;
        o_q_pop = w_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_radius  <= WHEEL_RADIUS_RST;
            r_angular_ratio <= ANGULAR_RATIO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WHEEL_RADIUS:  r_wheel_radius  <= i_cfg_wdata[15:0];
                CFG_ANGULAR_RATIO: r_angular_ratio <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
            r_omega     <= '0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_start) begin
                unique case (i_q_item.kind)
                    OP_SET_POSE: begin
                        r_pos_x     <= i_q_item.set_x;
                        r_pos_y     <= i_q_item.set_y;
                        r_heading   <= wrap_heading({{11{i_q_item.set_theta[19]}},
                                                     i_q_item.set_theta});
                        r_out_valid <= 1'b1;
                    end
                    OP_CLEAR: begin
                        r_pos_x     <= '0;
                        r_pos_y     <= '0;
                        r_heading   <= '0;
                        r_vx        <= '0;
                        r_vy        <= '0;
                        r_omega     <= '0;
                        r_out_valid <= 1'b1;
                    end
                    OP_NONE:   r_out_valid <= 1'b1;
                    OP_UPDATE: ;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_VEL: begin
                    r_vx <= sat_24(w_vel_rnd[0]);
                    r_vy <= sat_24(w_vel_rnd[1]);
                end
                ST_OMEGA: begin
                    r_omega <= sat_24({{4{w_om_rnd[52]}}, w_om_rnd});
                    r_cnt   <= '0;
                end
                ST_CORDIC: r_cnt <= w_last_cordic ? '0 : r_cnt + 1'b1;
                ST_UPDATE: begin
                    r_pos_x     <= sat_32({r_pos_x[31], r_pos_x} + 33'(q_val(0)));
                    r_pos_y     <= sat_32({r_pos_y[31], r_pos_y} + 33'(q_val(1)));
                    r_heading   <= wrap_heading({{12{r_heading[18]}}, r_heading}
                                                + 31'(q_val(2)));
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_item <= i_q_item;
        end
        unique case (r_state)
            ST_MUL_R: begin
                for (int k = 0; k < 3; k++) begin
                    r_p1[k] <= w_s[k] * $signed({1'b0, r_wheel_radius});
                end
            end
            ST_MUL_K: begin
                for (int k = 0; k < 3; k++) begin
                    r_p2[k] <= r_p1[k] * $signed({1'b0, RIM_K});
                end
            end
            ST_VEL: r_lin_w <= w_vel_rnd[2][33:0];
            ST_OMEGA: begin
                r_cx <= CORDIC_GAIN;
                r_cy <= '0;
                if (w_z0 > HALF_PI_Q24) begin
                    r_z    <= w_z0 - PI_Q24;
                    r_fold <= 1'b1;
                end else if (w_z0 < -HALF_PI_Q24) begin
                    r_z    <= w_z0 + PI_Q24;
                    r_fold <= 1'b1;
                end else begin
                    r_z    <= w_z0;
                    r_fold <= 1'b0;
                end
            end
            ST_CORDIC: begin
                if (r_z >= 0) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_z  <= r_z - atan_q24(r_cnt);
                end else begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_z  <= r_z + atan_q24(r_cnt);
                end
            end
            ST_ROT: begin
                r_m[0] <= r_vx * w_c;
                r_m[1] <= r_vy * w_s_rot;
                r_m[2] <= r_vx * w_s_rot;
                r_m[3] <= r_vy * w_c;
            end
            ST_SUM: begin
                r_wx <= w_sum_x[26:0];
                r_wy <= w_sum_y[26:0];
            end
            ST_DT: begin
                r_n[0] <= r_wx * w_dts;
                r_n[1] <= r_wy * w_dts;
                r_n[2] <= {{3{w_om_dt[44]}}, w_om_dt};
            end
            ST_DIV_SET: begin
                // floor division: negative numerators divide -n rounded up
                for (int k = 0; k < 3; k++) begin
                    r_qneg[k] <= (w_nh[k] < 0);
                    r_a[k]    <= w_mag[k][45:6];
                end
            end
            ST_DIV_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_qe[k] <= w_qp[k][52:26];
                end
            end
            ST_DIV_REM: begin
                for (int k = 0; k < 3; k++) begin
                    r_rem[k] <= w_r[k][15:0];
                end
            end
            ST_DIV_FIX: begin
                for (int k = 0; k < 3; k++) begin
                    r_qe[k] <= r_qe[k] + {25'd0, w_corr[k]};
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_omega, r_vy, r_vx, r_heading, r_pos_y, r_pos_x};

endmodule
`default_nettype wire

### src/mecanum_odometry_integrator_unit.sv
// Top level of the mecanum odometry integrator: input queue plus execution unit.
`default_nettype none
// Works on one item at a time. Set-pose, clear and unused-op items show their
// result the cycle after they leave the two-entry input queue; a wheel update shows
// it after the kinematics, the CORDIC loop at one step per cycle, the rotation, the
// time scaling and the division of the three increments by one million
// (reciprocal estimate, remainder, fix-up). The next item leaves the queue the cycle
// after the previous result is taken, so a new update starts only once the last
// result is out; meanwhile up to two items wait in the queue. Pose and velocity
// fields of each result are the state after that item.
module mecanum_odometry_integrator_unit
    import omi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [W_CFG_IDX-1:0]  i_cfg_index,
    input  wire logic [W_CFG_DATA-1:0] i_cfg_wdata,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // wheel_rpm_0, wheel_rpm_1, wheel_rpm_2, wheel_rpm_3, delta_time_us,
    // set_x, set_y, set_theta
    input  wire logic [167:0]          i_s_axis_tdata,
    // op
    input  wire logic [1:0]            i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // pose_x_out, pose_y_out, heading_out, body_vx, body_vy, body_omega, zero fill
    output logic [159:0]               o_m_axis_tdata
);

    logic  w_q_valid, w_q_pop;
    t_item w_q_item;

    omi_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_q_valid       (w_q_valid),
        .o_q_item        (w_q_item),
        .i_q_pop         (w_q_pop)
    );

    omi_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

### src/omi_checker.sv
// Port-level checks for the mecanum odometry integrator, bound to the top level.
`default_nettype none
module omi_checker
    import omi_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_cfg_we,
    input wire logic [W_CFG_IDX-1:0]  i_cfg_index,
    input wire logic [W_CFG_DATA-1:0] i_cfg_wdata,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic [167:0]          i_s_axis_tdata,
    input wire logic [1:0]            i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [159:0]          o_m_axis_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[82:64]) <= 19'sd205887)
                         && ($signed(o_m_axis_tdata[82:64]) >= -19'sd205887))
        else $error("heading outside +-pi");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind mecanum_odometry_integrator_unit omi_checker u_omi_checker (.*);
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the mecanum odometry integrator unit.
`timescale 1ns / 1ps
module tb;
    import omi_pkg::*;

    typedef struct {
        t_op                kind;
        logic signed [15:0] rpm [4];
        logic [19:0]        dt;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [19:0] sth;
    } t_cmd;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [18:0] h;
        logic [23:0] vx;
        logic [23:0] vy;
        logic [23:0] w;
    } t_pose;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [W_CFG_IDX-1:0]  i_cfg_index = '0;
    logic [W_CFG_DATA-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [167:0]          i_s_axis_tdata = '0;
    logic [1:0]            i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [159:0]          o_m_axis_tdata;

    mecanum_odometry_integrator_unit DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    longint radius_q16 = 3277, ratio_q16 = 32768;
    longint px = 0, py = 0, hd = 0, vx = 0, vy = 0, vw = 0;

    t_cmd   pending_cmds [$];
    t_pose  expected_poses [$];
    int     errors = 0;
    int     send_idle_pct = 0, recv_stall_pct = 0;

    function automatic longint floor_div(longint p, longint d);
        longint q;
        q = p / d;
        if ((p % d) != 0 && p < 0) q--;
        return q;
    endfunction

    function automatic longint round_div(longint p, longint d);
        return floor_div(p + d / 2, d);
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint wrap_angle(longint a);
        if (a > 205887) a -= 411775;
        else if (a < -205887) a += 411775;
        if (a > 205887) a = 205887;
        if (a < -205887) a = -205887;
        return a;
    endfunction

    function automatic void heading_sincos(input longint h, output longint c,
                                           output longint s);
        longint atans [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
        longint z, x, y, nx, xs, ys;
        bit flip;
        z = h * 256; x = 652032874; y = 0; flip = 0;
        if (z > 26353589) begin z -= 52707179; flip = 1; end
        else if (z < -26353589) begin z += 52707179; flip = 1; end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i; ys = y >>> i;
            if (z >= 0) begin nx = x - ys; y = y + xs; z -= atans[i]; end
            else begin nx = x + ys; y = y - xs; z += atans[i]; end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_pose integrate_odometry(t_cmd cmd);
        longint w[4], rk, sx, sy, sw, lin, c, s, wx, wy, dt;
        t_pose r;
        if (cmd.kind == OP_UPDATE) begin
            foreach (w[i]) w[i] = cmd.rpm[i];
            dt = cmd.dt;
            rk = radius_q16 * 1756906;
            sx = w[0] + w[1] + w[2] + w[3];
            sy = -w[0] + w[1] + w[2] - w[3];
            sw = -w[0] + w[1] - w[2] + w[3];
            lin = round_div(sw * rk, 64'd1 << 21);
            vx = clamp(round_div(sx * rk, 64'd1 << 29), 24);
            vy = clamp(round_div(sy * rk, 64'd1 << 29), 24);
            vw = clamp(round_div(lin * ratio_q16, 64'd1 << 24), 24);
            heading_sincos(hd, c, s);
            wx = round_div(vx * c - vy * s, 64'd1 << 30);
            wy = round_div(vx * s + vy * c, 64'd1 << 30);
            px = clamp(px + round_div(wx * dt, 1000000), 32);
            py = clamp(py + round_div(wy * dt, 1000000), 32);
            hd = wrap_angle(hd + round_div(vw * dt, 1000000));
        end else if (cmd.kind == OP_SET_POSE) begin
            px = cmd.sx; py = cmd.sy; hd = wrap_angle(cmd.sth);
        end else if (cmd.kind == OP_CLEAR) begin
            px = 0; py = 0; hd = 0; vx = 0; vy = 0; vw = 0;
        end
        r.x = px[31:0]; r.y = py[31:0]; r.h = hd[18:0];
        r.vx = vx[23:0]; r.vy = vy[23:0]; r.w = vw[23:0];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_cmd c;
                    c = pending_cmds.pop_front();
                    expected_poses.push_back(integrate_odometry(c));
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser  <= c.kind;
                    i_s_axis_tdata  <= {c.sth, c.sy, c.sx, c.dt,
                                        c.rpm[3], c.rpm[2], c.rpm[1], c.rpm[0]};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_poses.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                t_pose e;
                e = expected_poses.pop_front();
                if (o_m_axis_tdata[31:0] !== e.x) begin
                    $error("pose_x_out exp %h got %h", e.x, o_m_axis_tdata[31:0]); errors++;
                end
                if (o_m_axis_tdata[63:32] !== e.y) begin
                    $error("pose_y_out exp %h got %h", e.y, o_m_axis_tdata[63:32]); errors++;
                end
                if (o_m_axis_tdata[82:64] !== e.h) begin
                    $error("heading_out exp %h got %h", e.h, o_m_axis_tdata[82:64]); errors++;
                end
                if (o_m_axis_tdata[106:83] !== e.vx) begin
                    $error("body_vx exp %h got %h", e.vx, o_m_axis_tdata[106:83]); errors++;
                end
                if (o_m_axis_tdata[130:107] !== e.vy) begin
                    $error("body_vy exp %h got %h", e.vy, o_m_axis_tdata[130:107]); errors++;
                end
                if (o_m_axis_tdata[154:131] !== e.w) begin
                    $error("body_omega exp %h got %h", e.w, o_m_axis_tdata[154:131]);
                    errors++;
                end
            end
        end
    end

    function automatic t_cmd random_cmd();
        t_cmd c;
        int r;
        r = $urandom_range(99);
        c.kind = r < 75 ? OP_UPDATE : r < 88 ? OP_SET_POSE : r < 95 ? OP_CLEAR : OP_NONE;
        foreach (c.rpm[i]) c.rpm[i] = ($urandom_range(3) == 0) ? $urandom()
                                     : $signed($urandom_range(4000)) - 2000;
        c.dt = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(50000);
        c.sx = $urandom();
        c.sy = $urandom();
        c.sth = $signed($urandom_range(823548)) - 411774;
        return c;
    endfunction

    function automatic t_cmd make_cmd(t_op k, int r0, int r1, int r2, int r3,
                                      int dt, int sx, int sy, int sth);
        t_cmd c;
        c.kind = k; c.rpm[0] = r0; c.rpm[1] = r1; c.rpm[2] = r2; c.rpm[3] = r3;
        c.dt = dt; c.sx = sx; c.sy = sy; c.sth = sth;
        return c;
    endfunction

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_poses.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [W_CFG_IDX-1:0] idx, longint val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_wdata <= W_CFG_DATA'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_WHEEL_RADIUS) radius_q16 = val & 16'hFFFF;
        else ratio_q16 = val & 18'h3FFFF;
    endtask

    initial begin
        int pct [4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{30, 30}};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, every op, wrap and saturation cases
        pending_cmds.push_back(make_cmd(OP_UPDATE, 8000, 8000, 8000, 8000, 100000, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_UPDATE, -8000, 8000, -8000, 8000, 1048575,
                                        0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_UPDATE, 1, 2, 3, 4, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_SET_POSE, 0, 0, 0, 0, 0,
                                        32'h7FFFFF00, 32'h80000100, 411774));
        pending_cmds.push_back(make_cmd(OP_UPDATE, 32767, 32767, 32767, 32767, 1048575,
                                        0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_UPDATE, -32768, -32768, -32768, -32768,
                                        1048575, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_SET_POSE, 0, 0, 0, 0, 0, 5, -5, -411774));
        pending_cmds.push_back(make_cmd(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 0, 205888));
        pending_cmds.push_back(make_cmd(OP_SET_POSE, 0, 0, 0, 0, 0, 0, 0, -205887));
        pending_cmds.push_back(make_cmd(OP_UPDATE, 32767, -32768, 32767, -32768, 1048575,
                                        0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_NONE, -1, -1, -1, -1, 20'hFFFFF, -1, -1, -1));
        pending_cmds.push_back(make_cmd(OP_SET_POSE, 0, 0, 0, 0, 0, 100, 200, 150000));
        pending_cmds.push_back(make_cmd(OP_UPDATE, -32768, 32767, 32767, -32768, 500000,
                                        0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();
        write_reg(CFG_WHEEL_RADIUS, 65535);
        write_reg(CFG_ANGULAR_RATIO, 262143);
        pending_cmds.push_back(make_cmd(OP_UPDATE, 32767, -32768, 32767, -32768, 1048575,
                                        0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_UPDATE, 32767, 32767, -32768, -32768, 1048575,
                                        0, 0, 0));
        drain();
        write_reg(CFG_WHEEL_RADIUS, 0);
        write_reg(CFG_ANGULAR_RATIO, 0);
        pending_cmds.push_back(make_cmd(OP_UPDATE, 1000, -1000, 300, 7, 1000, 0, 0, 0));
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_WHEEL_RADIUS, ph < 2 ? 3277 : $urandom_range(65535));
            write_reg(CFG_ANGULAR_RATIO, ph < 2 ? 32768 : $urandom_range(262143));
            send_idle_pct = pct[ph % 4][0];
            recv_stall_pct = pct[ph % 4][1];
            for (int n = 0; n < 200; n++) pending_cmds.push_back(random_cmd());
            drain();
        end
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### mecanum_odometry_integrator_unit.f
src/omi_pkg.sv
src/omi_front.sv
src/omi_back.sv
src/mecanum_odometry_integrator_unit.sv
src/omi_checker.sv
verif/tb.sv
